/* rtl/fully_assoc_cache_fifo_writeback_assert.svh */
`ifndef FULLY_ASSOC_CACHE_FIFO_WRITEBACK_ASSERT_SVH
`define FULLY_ASSOC_CACHE_FIFO_WRITEBACK_ASSERT_SVH

// same-cycle implication
`define FACFW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FACFW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/facfw_pkg.sv */
package facfw_pkg;

  localparam int LINES      = 256;
  localparam int ADDR_BITS  = 16;
  localparam int LINE_BITS  = $clog2(LINES);
  localparam int CNT_BITS   = 32;

  localparam int GROUP_SIZE  = 16;
  localparam int GROUP_BITS  = $clog2(GROUP_SIZE);
  localparam int GROUP_COUNT = (LINES + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int PAD_LINES   = GROUP_COUNT * GROUP_SIZE;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_REDUCE,
    ST_SELECT,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic                 cmp_en;
    logic                 fill_en;
    logic                 mark_dirty;
    logic                 is_write;
    logic [ADDR_BITS-1:0] tag;
    logic [LINE_BITS-1:0] hit_index;
  } cell_ctl_t;

  typedef struct packed {
    logic                 hit;
    logic                 victim_dirty;
    logic [LINE_BITS-1:0] index;
  } lookup_t;

endpackage

/* rtl/facfw_ram.sv */
module facfw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/facfw_cell.sv */
module facfw_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [facfw_pkg::LINE_BITS-1:0] index,
  input  facfw_pkg::cell_ctl_t            ctl,
  input  logic                            token_in,
  output logic                            token,
  output logic                            match,
  output logic                            victim_dirty
);

  logic [facfw_pkg::ADDR_BITS-1:0] line_tag;
  logic                            valid;
  logic                            dirty;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid        <= 1'b0;
      dirty        <= 1'b0;
      token        <= (index == '0);
      match        <= 1'b0;
      victim_dirty <= 1'b0;
    end else begin
      if (ctl.cmp_en) begin
        match        <= valid && (line_tag == ctl.tag);
        victim_dirty <= dirty && token;
      end
      if (ctl.fill_en) begin
        // replacement token moves one cell down the ring per fill
        token <= token_in;
        if (token) begin
          valid <= 1'b1;
          dirty <= ctl.is_write;
        end
      end else if (ctl.mark_dirty && (ctl.hit_index == index)) begin
        dirty <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fill_en && token) begin
      line_tag <= ctl.tag;
    end
  end

endmodule

/* rtl/facfw_reduce.sv */
module facfw_reduce (
  input  logic                        clk,
  input  logic [facfw_pkg::LINES-1:0] match,
  input  logic [facfw_pkg::LINES-1:0] victim_dirty,
  output facfw_pkg::lookup_t          result
);

  logic [facfw_pkg::PAD_LINES-1:0]  match_pad;
  logic [facfw_pkg::PAD_LINES-1:0]  dirty_pad;

  logic [facfw_pkg::GROUP_COUNT-1:0] grp_hit_next;
  logic [facfw_pkg::GROUP_COUNT-1:0] grp_dirty_next;
  logic [facfw_pkg::GROUP_BITS-1:0]  grp_off_next [facfw_pkg::GROUP_COUNT];

  logic [facfw_pkg::GROUP_COUNT-1:0] grp_hit;
  logic [facfw_pkg::GROUP_COUNT-1:0] grp_dirty;
  logic [facfw_pkg::GROUP_BITS-1:0]  grp_off [facfw_pkg::GROUP_COUNT];

  facfw_pkg::lookup_t result_next;

  assign match_pad = facfw_pkg::PAD_LINES'(match);
  assign dirty_pad = facfw_pkg::PAD_LINES'(victim_dirty);

  // first level: lowest match inside each group of lines
  always_comb begin
    for (int g = 0; g < facfw_pkg::GROUP_COUNT; g++) begin
      grp_hit_next[g]   = 1'b0;
      grp_off_next[g]   = '0;
      grp_dirty_next[g] = |dirty_pad[g*facfw_pkg::GROUP_SIZE +: facfw_pkg::GROUP_SIZE];
      for (int k = facfw_pkg::GROUP_SIZE - 1; k >= 0; k--) begin
        if (match_pad[g*facfw_pkg::GROUP_SIZE + k]) begin
          grp_hit_next[g] = 1'b1;
          grp_off_next[g] = facfw_pkg::GROUP_BITS'(k);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_hit   <= grp_hit_next;
    grp_dirty <= grp_dirty_next;
    grp_off   <= grp_off_next;
  end

  // second level: lowest group that matched
  always_comb begin
    result_next.hit          = |grp_hit;
    result_next.victim_dirty = |grp_dirty;
    result_next.index        = '0;
    for (int g = facfw_pkg::GROUP_COUNT - 1; g >= 0; g--) begin
      if (grp_hit[g]) begin
        result_next.index = facfw_pkg::LINE_BITS'(g * facfw_pkg::GROUP_SIZE)
                          + facfw_pkg::LINE_BITS'(grp_off[g]);
      end
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

/* rtl/fully_assoc_cache_fifo_writeback.sv */
// Fully associative cache tag store with FIFO (round-robin) replacement,
// write-back and write-allocate. Each input word is a read or write to an
// address; each produces one result word with hit, write-back flag, line,
// evicted dirty tag and six wrapping 32-bit event counters. Lines are a ring
// of cells that each hold tag, valid and dirty and compare in parallel; a
// one-hot replacement token passes to the next cell on every fill. An item
// is accepted only in the idle state, after the previous item has passed
// through cell compare, a two-level registered priority tree that finds the
// lowest hit line, and update. The update waits while a previous result is
// still stalled in the output register.
module fully_assoc_cache_fifo_writeback (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            command,
  input  logic [facfw_pkg::ADDR_BITS-1:0] address,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            hit,
  output logic                            writeback,
  output logic [facfw_pkg::LINE_BITS-1:0] line_index,
  output logic [facfw_pkg::ADDR_BITS-1:0] victim_address,
  output logic [facfw_pkg::CNT_BITS-1:0]  read_hit_count,
  output logic [facfw_pkg::CNT_BITS-1:0]  read_miss_count,
  output logic [facfw_pkg::CNT_BITS-1:0]  write_hit_count,
  output logic [facfw_pkg::CNT_BITS-1:0]  write_miss_count,
  output logic [facfw_pkg::CNT_BITS-1:0]  mem_read_count,
  output logic [facfw_pkg::CNT_BITS-1:0]  mem_write_count
);

  `include "fully_assoc_cache_fifo_writeback_assert.svh"

  facfw_pkg::state_t  state;
  facfw_pkg::state_t  state_next;
  facfw_pkg::cell_ctl_t ctl;
  facfw_pkg::lookup_t lookup;

  logic                            is_write;
  logic [facfw_pkg::ADDR_BITS-1:0] tag;
  logic [facfw_pkg::LINE_BITS-1:0] ptr;
  logic [facfw_pkg::ADDR_BITS-1:0] victim_tag;
  logic                            upd_go;

  logic [facfw_pkg::LINES-1:0] token;
  logic [facfw_pkg::LINES-1:0] match;
  logic [facfw_pkg::LINES-1:0] victim_dirty;

  logic [facfw_pkg::CNT_BITS-1:0] cnt_rd_hit;
  logic [facfw_pkg::CNT_BITS-1:0] cnt_rd_miss;
  logic [facfw_pkg::CNT_BITS-1:0] cnt_wr_hit;
  logic [facfw_pkg::CNT_BITS-1:0] cnt_wr_miss;
  logic [facfw_pkg::CNT_BITS-1:0] cnt_mem_rd;
  logic [facfw_pkg::CNT_BITS-1:0] cnt_mem_wr;

  logic [facfw_pkg::CNT_BITS-1:0] cnt_rd_hit_next;
  logic [facfw_pkg::CNT_BITS-1:0] cnt_rd_miss_next;
  logic [facfw_pkg::CNT_BITS-1:0] cnt_wr_hit_next;
  logic [facfw_pkg::CNT_BITS-1:0] cnt_wr_miss_next;
  logic [facfw_pkg::CNT_BITS-1:0] cnt_mem_rd_next;
  logic [facfw_pkg::CNT_BITS-1:0] cnt_mem_wr_next;

  logic miss_wb;

  for (genvar i = 0; i < facfw_pkg::LINES; i++) begin : g_cell
    facfw_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .index        (facfw_pkg::LINE_BITS'(i)),
      .ctl          (ctl),
      .token_in     (token[(i + facfw_pkg::LINES - 1) % facfw_pkg::LINES]),
      .token        (token[i]),
      .match        (match[i]),
      .victim_dirty (victim_dirty[i])
    );
  end

  facfw_reduce u_reduce (
    .clk          (clk),
    .match        (match),
    .victim_dirty (victim_dirty),
    .result       (lookup)
  );

  // copy of the tags for reading the victim at the replacement pointer
  facfw_ram #(
    .WIDTH (facfw_pkg::ADDR_BITS),
    .DEPTH (facfw_pkg::LINES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ctl.fill_en),
    .waddr (ptr),
    .wdata (tag),
    .raddr (ptr),
    .rdata (victim_tag)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      facfw_pkg::ST_IDLE:   if (in_valid) state_next = facfw_pkg::ST_LOOKUP;
      facfw_pkg::ST_LOOKUP: state_next = facfw_pkg::ST_REDUCE;
      facfw_pkg::ST_REDUCE: state_next = facfw_pkg::ST_SELECT;
      facfw_pkg::ST_SELECT: state_next = facfw_pkg::ST_UPDATE;
      facfw_pkg::ST_UPDATE: if (!out_valid || !out_stall) state_next = facfw_pkg::ST_IDLE;
      default:              state_next = facfw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall       = (state != facfw_pkg::ST_IDLE);
    upd_go         = (state == facfw_pkg::ST_UPDATE) && (!out_valid || !out_stall);
    ctl.cmp_en     = (state == facfw_pkg::ST_LOOKUP);
    ctl.fill_en    = upd_go && !lookup.hit;
    ctl.mark_dirty = upd_go && lookup.hit && is_write;
    ctl.is_write   = is_write;
    ctl.tag        = tag;
    ctl.hit_index  = lookup.index;
  end

  assign miss_wb = !lookup.hit && lookup.victim_dirty;

  always_comb begin
    cnt_rd_hit_next  = cnt_rd_hit;
    cnt_rd_miss_next = cnt_rd_miss;
    cnt_wr_hit_next  = cnt_wr_hit;
    cnt_wr_miss_next = cnt_wr_miss;
    cnt_mem_rd_next  = cnt_mem_rd;
    cnt_mem_wr_next  = cnt_mem_wr;
    priority if (lookup.hit && is_write) begin
      cnt_wr_hit_next = cnt_wr_hit + 1'b1;
    end else if (lookup.hit) begin
      cnt_rd_hit_next = cnt_rd_hit + 1'b1;
    end else begin
      if (is_write) begin
        cnt_wr_miss_next = cnt_wr_miss + 1'b1;
      end else begin
        cnt_rd_miss_next = cnt_rd_miss + 1'b1;
      end
      cnt_mem_rd_next = cnt_mem_rd + 1'b1;
      if (lookup.victim_dirty) begin
        cnt_mem_wr_next = cnt_mem_wr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= facfw_pkg::ST_IDLE;
      ptr         <= '0;
      out_valid   <= 1'b0;
      cnt_rd_hit  <= '0;
      cnt_rd_miss <= '0;
      cnt_wr_hit  <= '0;
      cnt_wr_miss <= '0;
      cnt_mem_rd  <= '0;
      cnt_mem_wr  <= '0;
    end else begin
      state <= state_next;
      if (upd_go) begin
        out_valid   <= 1'b1;
        cnt_rd_hit  <= cnt_rd_hit_next;
        cnt_rd_miss <= cnt_rd_miss_next;
        cnt_wr_hit  <= cnt_wr_hit_next;
        cnt_wr_miss <= cnt_wr_miss_next;
        cnt_mem_rd  <= cnt_mem_rd_next;
        cnt_mem_wr  <= cnt_mem_wr_next;
        if (!lookup.hit) begin
          ptr <= (ptr == facfw_pkg::LINE_BITS'(facfw_pkg::LINES - 1)) ? '0 : ptr + 1'b1;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      is_write <= command;
      tag      <= address;
    end
    if (upd_go) begin
      hit              <= lookup.hit;
      writeback        <= miss_wb;
      line_index       <= lookup.hit ? lookup.index : ptr;
      victim_address   <= miss_wb ? victim_tag : '0;
      read_hit_count   <= cnt_rd_hit_next;
      read_miss_count  <= cnt_rd_miss_next;
      write_hit_count  <= cnt_wr_hit_next;
      write_miss_count <= cnt_wr_miss_next;
      mem_read_count   <= cnt_mem_rd_next;
      mem_write_count  <= cnt_mem_wr_next;
    end
  end

  `FACFW_ASSERT_NOW(a_token_onehot, clk, rst, 1'b1, $onehot(token), "replacement token lost")
  `FACFW_ASSERT_NEXT(a_accept_lookup, clk, rst, in_valid && !in_stall,
                     state == facfw_pkg::ST_LOOKUP, "accepted word did not start lookup")
  `FACFW_ASSERT_NEXT(a_update_out, clk, rst, upd_go, out_valid, "update did not present a result")
  `FACFW_ASSERT_NEXT(a_ptr_step, clk, rst,
                     upd_go && !lookup.hit &&
                     (ptr != facfw_pkg::LINE_BITS'(facfw_pkg::LINES - 1)),
                     ptr == $past(ptr) + 1'b1, "replacement pointer did not advance")
  `FACFW_ASSERT_NEXT(a_token_ptr, clk, rst, state == facfw_pkg::ST_LOOKUP, token[ptr],
                     "token and pointer disagree")

endmodule
